FILE: rtl/rfcc_pkg.sv
// Package for the range frame CRC-8 checker.
// Holds the result type, status and kind codes, frame positions and the CRC-8 update.
// Used by every module of the checker; depends on nothing.
`timescale 1ns / 1ps

package rfcc_pkg;

   localparam int unsigned FRAME_BYTES = 4;
   localparam int unsigned POS_W       = $clog2(FRAME_BYTES);

   localparam logic [POS_W-1:0] POS_HEADER = POS_W'(0);
   localparam logic [POS_W-1:0] POS_LOW    = POS_W'(1);
   localparam logic [POS_W-1:0] POS_HIGH   = POS_W'(2);
   localparam logic [POS_W-1:0] POS_CRC    = POS_W'(FRAME_BYTES - 1);

   localparam logic [7:0] HEADER_RESET = 8'h54;
   localparam logic [7:0] CRC_POLY     = 8'h8C;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_HDR_BAD = 2'd1;
   localparam logic [1:0] STATUS_CRC_BAD = 2'd2;

   localparam logic [1:0] KIND_NORMAL  = 2'd0;
   localparam logic [1:0] KIND_MINIMUM = 2'd1;
   localparam logic [1:0] KIND_INVALID = 2'd2;
   localparam logic [1:0] KIND_BEYOND  = 2'd3;

   localparam logic [15:0] DIST_MINIMUM = 16'h0000;
   localparam logic [15:0] DIST_INVALID = 16'h0001;
   localparam logic [15:0] DIST_BEYOND  = 16'hFFFF;

   localparam int unsigned RSP_DATA_W = 24;

   typedef struct packed {
      logic [1:0]  reading_kind;
      logic [15:0] distance;
      logic [1:0]  frame_status;
   } rfcc_result_type;

   // Reflected CRC-8, one byte, bit by bit.
   function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

FILE: rtl/rfcc_in_reg.sv
// Input register of the range frame CRC-8 checker.
// Captures one received byte per beat and holds it until the frame logic takes it.
// Depends on rfcc_pkg.
`timescale 1ns / 1ps

module rfcc_in_reg
   import rfcc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,
   input  logic       byte_take,
   output logic       byte_valid,
   output logic [7:0] byte_data
);

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] data_ff;
   logic       load;

   assign req_tready = !valid_ff || byte_take;
   assign load       = req_tvalid && req_tready;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (byte_take) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= req_tdata;
      end
   end

   assign byte_valid = valid_ff;
   assign byte_data  = data_ff;

endmodule

FILE: rtl/rfcc_frame_check.sv
// Frame tracker of the range frame CRC-8 checker.
// Keeps byte position, running CRC, header match and data bytes, and builds the result.
// Depends on rfcc_pkg.
`timescale 1ns / 1ps

module rfcc_frame_check
   import rfcc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_wr,
   input  logic [7:0]      csr_wdata,
   input  logic            byte_valid,
   input  logic [7:0]      byte_data,
   input  logic            out_free,
   output logic            byte_take,
   output logic            res_valid,
   output rfcc_result_type res
);

   logic [7:0]       header_ff;
   logic [POS_W-1:0] pos_ff;
   logic [POS_W-1:0] pos_in;
   logic [7:0]       crc_ff;
   logic [7:0]       crc_in;
   logic             hdr_ok_ff;
   logic [7:0]       low_ff;
   logic [7:0]       high_ff;
   logic [15:0]      frame_dist;
   logic             at_crc;

   assign at_crc     = (pos_ff == POS_CRC);
   assign byte_take  = byte_valid && (!at_crc || out_free);
   assign res_valid  = byte_take && at_crc;
   assign frame_dist = {high_ff, low_ff};

   always_comb begin
      pos_in = pos_ff;
      crc_in = crc_ff;
      if (byte_take) begin
         if (at_crc) begin
            pos_in = POS_HEADER;
            crc_in = 8'h00;
         end else begin
            pos_in = pos_ff + POS_W'(1);
            crc_in = crc8_update(crc_ff, byte_data);
         end
      end
   end

   always_comb begin
      res = '0;
      if (!hdr_ok_ff) begin
         res.frame_status = STATUS_HDR_BAD;
      end else if (crc_ff != byte_data) begin
         res.frame_status = STATUS_CRC_BAD;
      end else begin
         res.frame_status = STATUS_OK;
         res.distance     = frame_dist;
         if (frame_dist == DIST_MINIMUM) begin
            res.reading_kind = KIND_MINIMUM;
         end else if (frame_dist == DIST_INVALID) begin
            res.reading_kind = KIND_INVALID;
         end else if (frame_dist == DIST_BEYOND) begin
            res.reading_kind = KIND_BEYOND;
         end else begin
            res.reading_kind = KIND_NORMAL;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff <= HEADER_RESET;
         pos_ff    <= POS_HEADER;
         crc_ff    <= 8'h00;
         hdr_ok_ff <= 1'b0;
      end else begin
         if (csr_wr) begin
            header_ff <= csr_wdata;
         end
         pos_ff <= pos_in;
         crc_ff <= crc_in;
         if (byte_take && (pos_ff == POS_HEADER)) begin
            hdr_ok_ff <= (byte_data == header_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (byte_take && (pos_ff == POS_LOW)) begin
         low_ff <= byte_data;
      end
      if (byte_take && (pos_ff == POS_HIGH)) begin
         high_ff <= byte_data;
      end
   end

endmodule

FILE: rtl/rfcc_out_reg.sv
// Result register of the range frame CRC-8 checker.
// Holds one finished result until the receiver takes it, and packs it into the beat.
// Depends on rfcc_pkg.
`timescale 1ns / 1ps

module rfcc_out_reg
   import rfcc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  res_valid,
   input  rfcc_result_type       res,
   output logic                  out_free,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic            valid_ff;
   logic            valid_in;
   rfcc_result_type data_ff;

   assign out_free = !valid_ff || rsp_tready;

   always_comb begin
      if (res_valid) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         data_ff <= res;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W - $bits(rfcc_result_type))'(0), data_ff};

endmodule

FILE: rtl/range_frame_crc8_checker_core.sv
// Top level of the range frame CRC-8 checker.
// Instantiates rfcc_in_reg, rfcc_frame_check and rfcc_out_reg; depends on rfcc_pkg.
//
// The req channel carries one received byte per beat. Bytes form frames of four:
// header, low data byte, high data byte and CRC-8 over the first three bytes.
// The fourth byte of each frame produces one beat on the rsp channel with the
// frame status, the 16-bit distance and its reading kind; other bytes produce none.
// The csr channel writes the expected header byte; csr_ready is always high. The user
// must write it only while no frame is in flight; the block itself does not enforce it.
// A byte is captured in an input register and then checked by the frame logic; a
// CRC byte's result is stored in the output register, which offers it on rsp.
// One byte is accepted every cycle unless a CRC byte waits for the output
// register; the CRC update and compare are combinational.
// Synchronous reset clears position, CRC and both valid flags, and sets the
// expected header to 0x54. When the receiver stalls with a result held, bytes
// that complete no frame are still accepted; a CRC byte waits until the output
// register frees, and req_tready then drops once the input register is full.
`timescale 1ns / 1ps

module range_frame_crc8_checker_core
   import rfcc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [7:0] rx_byte
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [1:0] frame_status, [17:2] distance,
                                              // [19:18] reading_kind, [23:20] zero
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [7:0]            csr_data     // [7:0] header_value
);

   logic            byte_valid;
   logic [7:0]      byte_data;
   logic            byte_take;
   logic            out_free;
   logic            res_valid;
   rfcc_result_type res;

   assign csr_ready = 1'b1;

   rfcc_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .byte_take  (byte_take),
      .byte_valid (byte_valid),
      .byte_data  (byte_data)
   );

   rfcc_frame_check u_frame_check (
      .clock      (clock),
      .reset      (reset),
      .csr_wr     (csr_valid && csr_ready),
      .csr_wdata  (csr_data),
      .byte_valid (byte_valid),
      .byte_data  (byte_data),
      .out_free   (out_free),
      .byte_take  (byte_take),
      .res_valid  (res_valid),
      .res        (res)
   );

   rfcc_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .res_valid  (res_valid),
      .res        (res),
      .out_free   (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

FILE: rtl/rfcc_checker.sv
// Port checker of the range frame CRC-8 checker, bound to the top level.
// Watches only the top-level ports; depends on rfcc_pkg.
`timescale 1ns / 1ps

module rfcc_checker
   import rfcc_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   // A reset leaves no result pending.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result beat valid right after reset");

   // A stalled result beat stays and holds its data.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result beat changed");

   // A failed frame carries no distance and no kind, and the padding stays zero.
   a_fail_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[1:0] != STATUS_OK) |-> rsp_tdata[RSP_DATA_W-1:2] == '0)
      else $error("failed frame carries data");

   // Only the three defined status codes appear.
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[1:0] == STATUS_OK || rsp_tdata[1:0] == STATUS_HDR_BAD
                      || rsp_tdata[1:0] == STATUS_CRC_BAD))
      else $error("undefined frame status");

   // The reading kind agrees with the distance of a good frame.
   a_kind_match: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[1:0] == STATUS_OK) |->
         ((rsp_tdata[19:18] == KIND_MINIMUM) == (rsp_tdata[17:2] == DIST_MINIMUM))
         && ((rsp_tdata[19:18] == KIND_INVALID) == (rsp_tdata[17:2] == DIST_INVALID))
         && ((rsp_tdata[19:18] == KIND_BEYOND) == (rsp_tdata[17:2] == DIST_BEYOND)))
      else $error("reading kind does not match distance");

endmodule

bind range_frame_crc8_checker_core rfcc_checker u_rfcc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

FILE: tb/tb_range_frame_crc8_checker_core.sv
// Testbench for range_frame_crc8_checker_core: drives four-byte frames on the req stream,
// predicts every result with a scoreboard class and checks each rsp beat against it.
// Depends on rfcc_pkg and the checker RTL.
`timescale 1ns / 1ps

module tb_range_frame_crc8_checker_core;
   import rfcc_pkg::*;

   class range_frame_predictor;
      logic [7:0]      header_value;
      logic [1:0]      position;
      logic [7:0]      crc;
      bit              hdr_ok;
      logic [7:0]      lo;
      logic [7:0]      hi;
      rfcc_result_type awaited_readings[$];
      int unsigned     errors;

      function new();
         header_value = HEADER_RESET;
         position     = POS_HEADER;
         crc          = 8'h00;
         hdr_ok       = 1'b0;
         lo           = 8'h00;
         hi           = 8'h00;
         errors       = 0;
      endfunction

      function logic [7:0] crc_next(logic [7:0] acc, logic [7:0] b);
         logic [7:0] v;
         v = acc ^ b;
         repeat (8) v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
         return v;
      endfunction

      function void note_byte(logic [7:0] b);
         rfcc_result_type r;
         if (position != POS_CRC) begin
            case (position)
               POS_HEADER: begin
                  hdr_ok = (b == header_value);
               end
               POS_LOW: begin
                  lo = b;
               end
               default: begin
                  hi = b;
               end
            endcase
            crc      = crc_next(crc, b);
            position = position + 2'd1;
         end else begin
            r = '0;
            if (!hdr_ok) begin
               r.frame_status = STATUS_HDR_BAD;
            end else if (crc != b) begin
               r.frame_status = STATUS_CRC_BAD;
            end else begin
               r.frame_status = STATUS_OK;
               r.distance     = {hi, lo};
               if (r.distance == DIST_MINIMUM) begin
                  r.reading_kind = KIND_MINIMUM;
               end else if (r.distance == DIST_INVALID) begin
                  r.reading_kind = KIND_INVALID;
               end else if (r.distance == DIST_BEYOND) begin
                  r.reading_kind = KIND_BEYOND;
               end else begin
                  r.reading_kind = KIND_NORMAL;
               end
            end
            awaited_readings.push_back(r);
            position = POS_HEADER;
            crc      = 8'h00;
         end
      endfunction

      function void check_reading(logic [RSP_DATA_W-1:0] d);
         rfcc_result_type got;
         rfcc_result_type want;
         got = rfcc_result_type'(d[19:0]);
         if (awaited_readings.size() == 0) begin
            errors++;
            if (errors <= 10) begin
               $display("unexpected result beat: status %0d distance %h kind %0d",
                        got.frame_status, got.distance, got.reading_kind);
            end
         end else begin
            want = awaited_readings.pop_front();
            if (got.frame_status != want.frame_status || got.distance != want.distance ||
                got.reading_kind != want.reading_kind) begin
               errors++;
               if (errors <= 10) begin
                  $display("mismatch: expected status %0d distance %h kind %0d, got status %0d distance %h kind %0d",
                           want.frame_status, want.distance, want.reading_kind,
                           got.frame_status, got.distance, got.reading_kind);
               end
            end
         end
      endfunction

      function int pending();
         return awaited_readings.size();
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [7:0]            req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [7:0]            csr_data;

   range_frame_predictor sb = new();
   bit                   hold_rsp = 1'b0;
   bit                   burst_mode = 1'b0;

   range_frame_crc8_checker_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("FAILURE");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) begin
         return 0;
      end else if (r < 95) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 40);
   endfunction

   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = burst_mode ? 0 : pick_gap();
      if (gap > 0) begin
         @(negedge clock) req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_byte(b);
   endtask

   task automatic stop_sending();
      @(negedge clock) req_tvalid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (sb.pending() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_header(input logic [7:0] v);
      wait_drained();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.header_value = v;
      @(negedge clock) csr_valid <= 1'b0;
   endtask

   task automatic send_frame(input logic [7:0] h, input logic [7:0] lo, input logic [7:0] hi,
                             input bit bad_crc);
      logic [7:0] c;
      c = sb.crc_next(sb.crc_next(sb.crc_next(8'h00, h), lo), hi);
      if (bad_crc) begin
         c = c ^ 8'($urandom_range(1, 255));
      end
      send_byte(h);
      send_byte(lo);
      send_byte(hi);
      send_byte(c);
   endtask

   task automatic run_phase(input int frames, input int phase);
      int         r;
      logic [7:0] h;
      logic [7:0] lo;
      logic [7:0] hi;
      burst_mode = (phase == 3);
      for (int f = 0; f < frames; f++) begin
         if (phase == 1 && f == 20) begin
            hold_rsp = 1'b1;
         end
         if (phase == 2 && f == 35) begin
            stop_sending();
            wait_drained();
         end
         h  = sb.header_value;
         lo = 8'($urandom);
         hi = 8'($urandom);
         if ($urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 4))
               0: {hi, lo} = DIST_MINIMUM;
               1: {hi, lo} = DIST_INVALID;
               2: {hi, lo} = DIST_BEYOND;
               3: {hi, lo} = 16'h0002;
               default: {hi, lo} = 16'hFFFE;
            endcase
         end
         r = $urandom_range(0, 99);
         if (r < 75) begin
            send_frame(h, lo, hi, 1'b0);
         end else if (r < 84) begin
            send_frame(h ^ 8'($urandom_range(1, 255)), lo, hi, 1'($urandom_range(0, 1)));
         end else if (r < 92) begin
            send_frame(h, lo, hi, 1'b1);
         end else begin
            repeat (4) send_byte(8'($urandom));
         end
      end
      burst_mode = 1'b0;
      stop_sending();
   endtask

   initial begin
      int  len;
      bit  val;
      int  r;
      rsp_tready = 1'b0;
      forever begin
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            repeat (300) @(negedge clock) rsp_tready <= 1'b0;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
               val = 1'b1;
               len = $urandom_range(1, 8);
            end else if (r < 62) begin
               val = 1'b1;
               len = 60;
            end else if (r < 95) begin
               val = 1'b0;
               len = $urandom_range(1, 3);
            end else begin
               val = 1'b0;
               len = $urandom_range(10, 40);
            end
            repeat (len) @(negedge clock) rsp_tready <= val;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_reading(rsp_tdata);
      end
   end

   initial begin
      logic [7:0] v;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = 8'h00;
      csr_valid  = 1'b0;
      csr_data   = 8'h00;
      repeat (11) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // The reset header value is used for the first frames.
      send_frame(HEADER_RESET, 8'h00, 8'h00, 1'b0);
      send_frame(HEADER_RESET, 8'h01, 8'h00, 1'b0);
      send_frame(HEADER_RESET, 8'hFF, 8'hFF, 1'b0);
      send_frame(8'hFF, 8'h80, 8'h7F, 1'b0);
      send_frame(HEADER_RESET, 8'h5A, 8'hA5, 1'b1);
      send_frame(~HEADER_RESET, 8'h00, 8'hFF, 1'b1);
      stop_sending();

      for (int p = 0; p < 6; p++) begin
         case (p)
            0: v = 8'h00;
            1: v = 8'hFF;
            2: v = HEADER_RESET;
            default: v = 8'($urandom);
         endcase
         write_header(v);
         run_phase(70, p);
      end

      wait_drained();
      repeat (10) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/rfcc_pkg.sv
rtl/rfcc_in_reg.sv
rtl/rfcc_frame_check.sv
rtl/rfcc_out_reg.sv
rtl/range_frame_crc8_checker_core.sv
rtl/rfcc_checker.sv
tb/tb_range_frame_crc8_checker_core.sv
